>>> rtl/core/fwe_pkg.sv
// Shared types and constants for the watermark FIFO.
package fwe_pkg;

   // Fixed field widths
   localparam int DATA_BITS   = 64;
   localparam int MARK_BITS   = 6;
   localparam int STATUS_BITS = 2;
   localparam int CSR_IDX_BITS = 1;

   // Request kinds carried on req_tuser
   localparam logic REQ_PUSH = 1'b0;
   localparam logic REQ_POP  = 1'b1;

   // Configuration register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_LOW_MARK  = 1'b0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_HIGH_MARK = 1'b1;

   // Result status codes
   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   // Per-item status and level report from control to the result register
   typedef struct packed {
      status_type           status;
      logic [MARK_BITS-1:0] fill_level;
      logic                 high_event;
      logic                 low_event;
      logic                 at_or_above_high;
      logic                 at_or_below_low;
   } report_type;

endpackage

>>> rtl/core/fwe_store.sv
// Element memory with a registered read port that feeds the result data.
module fwe_store #(
   parameter int DEPTH     = 32,
   parameter int ELEM_BITS = 64
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [$clog2(DEPTH)-1:0]     wr_addr,
   input  logic [ELEM_BITS-1:0]         wr_data,
   input  logic                         load,      // item accepted this cycle
   input  logic                         rd_ok,     // successful pop
   input  logic [$clog2(DEPTH)-1:0]     rd_addr,
   output logic [fwe_pkg::DATA_BITS-1:0] rd_data
);
   import fwe_pkg::*;

   logic [ELEM_BITS-1:0] mem [DEPTH];
   logic [ELEM_BITS-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port; the register doubles as the result data and holds on stall
   always_ff @(posedge clock) begin
      if (load) begin
         rd_data_ff <= rd_ok ? mem[rd_addr] : '0;
      end
   end

   assign rd_data = DATA_BITS'(rd_data_ff);

endmodule

>>> rtl/core/fwe_ctrl.sv
// Pointers, fill count, refusal decision and watermark flags.
module fwe_ctrl #(
   parameter int DEPTH = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             accept,
   input  logic                             req_kind,
   input  logic [fwe_pkg::MARK_BITS-1:0]    low_mark,
   input  logic [fwe_pkg::MARK_BITS-1:0]    high_mark,
   output logic                             wr_en,
   output logic [$clog2(DEPTH)-1:0]         wr_addr,
   output logic                             rd_ok,
   output logic [$clog2(DEPTH)-1:0]         rd_addr,
   output fwe_pkg::report_type              report
);
   import fwe_pkg::*;

   localparam int PTR_BITS = $clog2(DEPTH);
   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam int CMP_BITS = (CNT_BITS > MARK_BITS) ? CNT_BITS : MARK_BITS;
   localparam logic [PTR_BITS-1:0] LAST_SLOT = PTR_BITS'(DEPTH - 1);
   localparam logic [CNT_BITS-1:0] FULL_CNT  = CNT_BITS'(DEPTH);

   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;

   logic                is_push, is_pop, push_ok, pop_ok;
   logic [CMP_BITS-1:0] before_w, after_w, low_w, high_w;

   // Decide and update
   always_comb begin
      is_push  = (req_kind == REQ_PUSH);
      is_pop   = (req_kind == REQ_POP);
      push_ok  = is_push && (count_ff != FULL_CNT);
      pop_ok   = is_pop && (count_ff != '0);

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
         count_in  = count_ff + 1'b1;
      end else if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
         count_in  = count_ff - 1'b1;
      end
   end

   // Level report after this item
   always_comb begin
      before_w = CMP_BITS'(count_ff);
      after_w  = CMP_BITS'(count_in);
      low_w    = CMP_BITS'(low_mark);
      high_w   = CMP_BITS'(high_mark);

      if (is_push && !push_ok) begin
         report.status = STATUS_FULL;
      end else if (is_pop && !pop_ok) begin
         report.status = STATUS_EMPTY;
      end else begin
         report.status = STATUS_DONE;
      end
      report.fill_level       = MARK_BITS'(count_in);
      report.high_event       = push_ok && (high_mark != '0) &&
                                (after_w >= high_w) && (before_w < high_w);
      report.low_event        = pop_ok && (low_mark != '0) &&
                                (after_w <= low_w) && (before_w > low_w);
      report.at_or_above_high = (high_mark == '0) || (after_w >= high_w);
      report.at_or_below_low  = (low_mark == '0) || (after_w <= low_w);
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else if (accept) begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign wr_en   = accept && push_ok;
   assign wr_addr = wr_ptr_ff;
   assign rd_ok   = pop_ok;
   assign rd_addr = rd_ptr_ff;

endmodule

>>> rtl/core/fifo_with_watermark_events.sv
// Top level of the FIFO with programmable high and low watermark events.
//
//   channel  dir  tdata (low bit up)                        tuser
//   req_     in   push_data[63:0]                           req_type (0 push, 1 pop)
//   rsp_     out  pop_data[63:0], fill_level[69:64],        status
//                 high_event[70], low_event[71],
//                 at_or_above_high[72], at_or_below_low[73]
//   csr_     in   csr_index 0 low_mark, 1 high_mark; csr_data[5:0]
//
// One item per cycle; its result is registered and shows in the cycle after it
// is accepted, with pop data read straight from the element memory into the
// result register. req_tready is high only while the result register is
// empty or being taken, so a stalled result holds off the next item. Reset
// clears the pointers, the fill count, both marks and the result valid;
// memory contents are not cleared and need no clearing pass.
module fifo_with_watermark_events #(
   parameter int DEPTH     = 32,
   parameter int ELEM_BITS = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [fwe_pkg::DATA_BITS-1:0]      req_tdata,   // push_data
   input  logic                               req_tuser,   // req_type
   // result channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [79:0]                        rsp_tdata,   // pop_data, fill_level,
                                                           // high_event, low_event,
                                                           // at_or_above_high,
                                                           // at_or_below_low
   output logic [fwe_pkg::STATUS_BITS-1:0]    rsp_tuser,   // status
   // configuration channel
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [fwe_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [fwe_pkg::MARK_BITS-1:0]      csr_data
);
   import fwe_pkg::*;

   localparam int PTR_BITS = $clog2(DEPTH);

   logic                 accept;
   logic                 rsp_valid_ff, rsp_valid_in;
   report_type           report_ff, report_in;
   logic [MARK_BITS-1:0] low_mark_ff, high_mark_ff;
   logic                 wr_en, rd_ok;
   logic [PTR_BITS-1:0]  wr_addr, rd_addr;
   logic [DATA_BITS-1:0] pop_data;

   // Handshake: take a new item whenever the result slot is free or frees this cycle
   assign req_tready   = !rsp_valid_ff || rsp_tready;
   assign accept       = req_tvalid && req_tready;
   assign rsp_valid_in = accept ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   assign csr_ready    = 1'b1;

   fwe_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req_kind  (req_tuser),
      .low_mark  (low_mark_ff),
      .high_mark (high_mark_ff),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .rd_ok     (rd_ok),
      .rd_addr   (rd_addr),
      .report    (report_in)
   );

   fwe_store #(
      .DEPTH     (DEPTH),
      .ELEM_BITS (ELEM_BITS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_tdata[ELEM_BITS-1:0]),
      .load    (accept),
      .rd_ok   (rd_ok),
      .rd_addr (rd_addr),
      .rd_data (pop_data)
   );

   // Result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result report payload
   always_ff @(posedge clock) begin
      if (accept) begin
         report_ff <= report_in;
      end
   end

   // Watermark registers
   always_ff @(posedge clock) begin
      if (reset) begin
         low_mark_ff  <= '0;
         high_mark_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_LOW_MARK:  low_mark_ff  <= csr_data;
            CSR_HIGH_MARK: high_mark_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Output packing
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = report_ff.status;
   assign rsp_tdata  = {6'b0,
                        report_ff.at_or_below_low,
                        report_ff.at_or_above_high,
                        report_ff.low_event,
                        report_ff.high_event,
                        report_ff.fill_level,
                        pop_data};

endmodule

>>> sim/tb_fifo_with_watermark_events.sv
// Self-checking testbench for the watermark FIFO: predicts every result and compares it.
module tb_fifo_with_watermark_events;
   import fwe_pkg::*;

   localparam int FIFO_DEPTH  = 32;
   localparam int HOLD_CYCLES = 120;

   // Expected result of one request
   typedef struct packed {
      status_type           status;
      logic [63:0]          pop_data;
      logic [MARK_BITS-1:0] fill_level;
      logic                 high_event;
      logic                 low_event;
      logic                 above_high;
      logic                 below_low;
   } fifo_result_type;

   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [DATA_BITS-1:0]    req_tdata  = '0;
   logic                    req_tuser  = REQ_PUSH;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [79:0]             rsp_tdata;
   logic [STATUS_BITS-1:0]  rsp_tuser;
   logic                    csr_valid  = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_BITS-1:0] csr_index  = CSR_LOW_MARK;
   logic [MARK_BITS-1:0]    csr_data   = '0;

   // Predictor state; pointers wrap on their own since the depth is a power of two
   logic [63:0]                     slot_mem [FIFO_DEPTH];
   logic [$clog2(FIFO_DEPTH)-1:0]   wr_ptr     = '0;
   logic [$clog2(FIFO_DEPTH)-1:0]   rd_ptr     = '0;
   int unsigned                     fill_count = 0;
   logic [MARK_BITS-1:0]            low_mark   = '0;
   logic [MARK_BITS-1:0]            high_mark  = '0;
   fifo_result_type                 pending_results [$];

   int   errors     = 0;
   logic idle_on    = 1'b0;
   int   hold_seq   = 0;
   int   hold_seen  = 0;
   int   stall_left = 0;

   fifo_with_watermark_events dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #1 clock = ~clock;

   // Apply one push or pop to the predicted FIFO and return its result
   function automatic fifo_result_type predict_fifo_result(logic kind, logic [63:0] data);
      fifo_result_type r;
      int unsigned     prior;
      prior        = fill_count;
      r            = '0;
      r.status     = STATUS_DONE;
      if (kind == REQ_PUSH) begin
         if (fill_count >= FIFO_DEPTH) begin
            r.status = STATUS_FULL;
         end else begin
            slot_mem[wr_ptr] = data;
            wr_ptr           = wr_ptr + 1'b1;
            fill_count       = fill_count + 1;
            r.high_event     = (high_mark != 0) && (fill_count >= high_mark)
                               && (prior < high_mark);
         end
      end else begin
         if (fill_count == 0) begin
            r.status = STATUS_EMPTY;
         end else begin
            r.pop_data  = slot_mem[rd_ptr];
            rd_ptr      = rd_ptr + 1'b1;
            fill_count  = fill_count - 1;
            r.low_event = (low_mark != 0) && (fill_count <= low_mark) && (prior > low_mark);
         end
      end
      r.fill_level = fill_count[MARK_BITS-1:0];
      r.above_high = (high_mark == 0) || (fill_count >= high_mark);
      r.below_low  = (low_mark == 0) || (fill_count <= low_mark);
      return r;
   endfunction

   task automatic report_mismatch(string field, logic [63:0] want, logic [63:0] got);
      errors++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
   endtask

   // Compare one accepted result with the oldest prediction
   task automatic check_result();
      fifo_result_type want;
      if (pending_results.size() == 0) begin
         report_mismatch("unexpected result", '0, rsp_tdata[63:0]);
      end else begin
         want = pending_results.pop_front();
         if (rsp_tuser !== want.status)
            report_mismatch("status", 64'(want.status), 64'(rsp_tuser));
         if (rsp_tdata[63:0] !== want.pop_data)
            report_mismatch("pop_data", want.pop_data, rsp_tdata[63:0]);
         if (rsp_tdata[69:64] !== want.fill_level)
            report_mismatch("fill_level", 64'(want.fill_level), 64'(rsp_tdata[69:64]));
         if (rsp_tdata[70] !== want.high_event)
            report_mismatch("high_event", 64'(want.high_event), 64'(rsp_tdata[70]));
         if (rsp_tdata[71] !== want.low_event)
            report_mismatch("low_event", 64'(want.low_event), 64'(rsp_tdata[71]));
         if (rsp_tdata[72] !== want.above_high)
            report_mismatch("at_or_above_high", 64'(want.above_high), 64'(rsp_tdata[72]));
         if (rsp_tdata[73] !== want.below_low)
            report_mismatch("at_or_below_low", 64'(want.below_low), 64'(rsp_tdata[73]));
         if (rsp_tdata[79:74] !== 6'd0)
            report_mismatch("tdata padding", '0, 64'(rsp_tdata[79:74]));
      end
   endtask

   // Monitor: mark writes, accepted requests and accepted results
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_LOW_MARK)
               low_mark = csr_data;
            else
               high_mark = csr_data;
         end
         if (req_tvalid && req_tready)
            pending_results.push_back(predict_fifo_result(req_tuser, req_tdata));
         if (rsp_tvalid && rsp_tready)
            check_result();
      end
   end

   // Result side: random stall bursts, plus a long hold when requested
   always @(posedge clock) begin
      if (hold_seq != hold_seen) begin
         hold_seen  = hold_seq;
         stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && idle_on && $urandom_range(0, 4) == 0) begin
         stall_left = $urandom_range(1, 6);
      end
      if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Offer one item; returns at the edge where it is taken, valid left high
   task automatic send_req(logic kind, logic [63:0] data);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= data;
      do @(posedge clock); while (!req_tready);
   endtask

   // Stop offering and wait until every predicted result has arrived
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic set_marks(logic [MARK_BITS-1:0] low, logic [MARK_BITS-1:0] high);
      wait_drained();
      csr_valid <= 1'b1;
      csr_index <= CSR_LOW_MARK;
      csr_data  <= low;
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_HIGH_MARK;
      csr_data  <= high;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [63:0] rand_data();
      case ($urandom_range(0, 15))
         0:       return '0;
         1:       return '1;
         default: return {$urandom(), $urandom()};
      endcase
   endfunction

   function automatic logic [MARK_BITS-1:0] rand_mark(bit extreme);
      int unsigned picks [6] = '{0, 1, 31, 32, 33, 63};
      if (extreme)
         return MARK_BITS'(picks[$urandom_range(0, 5)]);
      return MARK_BITS'($urandom_range(0, 33));
   endfunction

   // Refused pop, data extremes, crossings of small marks
   task automatic test_directed_basics();
      send_req(REQ_POP, 64'h0123_4567_89ab_cdef);
      send_req(REQ_PUSH, '0);
      send_req(REQ_PUSH, '1);
      send_req(REQ_PUSH, 64'haaaa_aaaa_aaaa_aaaa);
      send_req(REQ_PUSH, 64'h5555_5555_5555_5555);
      repeat (4) send_req(REQ_POP, '0);
      send_req(REQ_POP, '1);
      set_marks(6'd2, 6'd3);
      repeat (4) send_req(REQ_PUSH, rand_data());
      repeat (4) send_req(REQ_POP, rand_data());
      send_req(REQ_POP, '0);
   endtask

   // Fill to full with refused pushes, then drain past empty
   task automatic test_fill_and_drain();
      set_marks(6'd1, 6'd32);
      repeat (FIFO_DEPTH) send_req(REQ_PUSH, rand_data());
      send_req(REQ_PUSH, '1);
      send_req(REQ_PUSH, '0);
      repeat (FIFO_DEPTH) send_req(REQ_POP, rand_data());
      send_req(REQ_POP, '1);
   endtask

   // Biased random walks so the level sweeps the whole range under many marks
   task automatic test_random_traffic(int phases, int per_phase);
      int push_pct;
      for (int p = 0; p < phases; p++) begin
         set_marks(rand_mark(p % 3 == 0), rand_mark(p % 3 == 1));
         case (p % 3)
            0:       push_pct = 80;
            1:       push_pct = 20;
            default: push_pct = 50;
         endcase
         for (int i = 0; i < per_phase; i++)
            send_req(($urandom_range(0, 99) < push_pct) ? REQ_PUSH : REQ_POP, rand_data());
      end
   endtask

   // Long result hold while requests keep coming, so the input stalls
   task automatic test_backpressure();
      set_marks(rand_mark(1'b0), rand_mark(1'b0));
      idle_on  = 1'b0;
      hold_seq <= hold_seq + 1;
      for (int i = 0; i < 40; i++)
         send_req(($urandom_range(0, 2) != 0) ? REQ_PUSH : REQ_POP, rand_data());
      idle_on = 1'b1;
   endtask

   // Last stretch with both sides always ready
   task automatic test_steady_stream();
      set_marks(6'd63, 6'd63);
      idle_on = 1'b0;
      for (int i = 0; i < 60; i++)
         send_req(($urandom_range(0, 99) < 70) ? REQ_PUSH : REQ_POP, rand_data());
      set_marks(rand_mark(1'b0), rand_mark(1'b0));
      for (int i = 0; i < 60; i++)
         send_req(($urandom_range(0, 1) != 0) ? REQ_PUSH : REQ_POP, rand_data());
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset   <= 1'b0;
      idle_on <= 1'b1;
      @(posedge clock);
      test_directed_basics();
      test_fill_and_drain();
      test_random_traffic(7, 100);
      test_backpressure();
      test_steady_stream();
      wait_drained();
      if (errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // Watchdog
   initial begin
      #400000;
      $display("tb: failure");
      $finish;
   end

endmodule
